### src/seven_segment_number_scanner_unit_defines.svh
// ---------------------------------------------------------------------------
// Seven-segment number scanner: assertion macros
// Clocked on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_NUMBER_SCANNER_UNIT_DEFINES_SVH
`define SEVEN_SEGMENT_NUMBER_SCANNER_UNIT_DEFINES_SVH

// check cons in the same cycle as ante
`define SSCN_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// check cons in the cycle after ante
`define SSCN_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/sscn_pkg.sv
// ---------------------------------------------------------------------------
// Seven-segment number scanner package
// Digit count, derived widths, hand-off type and segment decode.
// ---------------------------------------------------------------------------
`default_nettype none

package sscn_pkg;

	localparam int DIGIT_COUNT = 4;
	localparam int MAX_POSITIONS = 4;
	localparam int DIG_EFF = (DIGIT_COUNT < 1) ? 1 :
		((DIGIT_COUNT > MAX_POSITIONS) ? MAX_POSITIONS : DIGIT_COUNT);

	function automatic int pow10(input int n);
		int r;
		r = 1;
		for (int i = 0; i < n; i++) begin
			r = r * 10;
		end
		return r;
	endfunction

	localparam int LIMIT = pow10(DIG_EFF);
	localparam int VALUE_W = 16;
	localparam int POS_W = 2;
	localparam int SEG_W = 7;
	localparam logic [VALUE_W-1:0] VALUE_MAX = VALUE_W'(LIMIT - 1);
	localparam int BIN_W = $clog2(LIMIT);
	localparam int BCD_W = 4 * DIG_EFF;
	localparam int CNT_W = $clog2(BIN_W + 1);
	localparam int REM_W = $clog2(DIG_EFF + 1);

	typedef struct packed {
		logic             valid;
		logic [BCD_W-1:0] bcd;
	} sscn_hand_t;

	function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] digit);
		logic [SEG_W-1:0] s;
		unique case (digit)
			4'd0:    s = 7'b1111110;
			4'd1:    s = 7'b0110000;
			4'd2:    s = 7'b1101101;
			4'd3:    s = 7'b1111001;
			4'd4:    s = 7'b0110011;
			4'd5:    s = 7'b1011011;
			4'd6:    s = 7'b1011111;
			4'd7:    s = 7'b1110000;
			4'd8:    s = 7'b1111111;
			4'd9:    s = 7'b1111011;
			default: s = '0;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

### src/sscn_conv.sv
// ---------------------------------------------------------------------------
// Binary to BCD converter
// Accepts a number, drops it when out of range, otherwise runs one
// add-3-and-shift step per cycle and holds the BCD word until handed off.
// ---------------------------------------------------------------------------
`default_nettype none
`include "seven_segment_number_scanner_unit_defines.svh"

module sscn_conv (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic signed [sscn_pkg::VALUE_W-1:0] value,
	input  wire logic                                value_valid,
	output logic                                     value_stall,
	input  wire logic                                hand_ready,
	output sscn_pkg::sscn_hand_t                     hand
);
	import sscn_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SHIFT = 2'd1;
	localparam logic [1:0] ST_HOLD  = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [BIN_W-1:0] bin_q;
	logic [BCD_W-1:0] bcd_q;
	logic [BCD_W-1:0] bcd_adj;
	logic             accept;
	logic             in_range;

	assign value_stall = (state_q != ST_IDLE);
	assign accept      = value_valid && !value_stall;
	assign in_range    = (value[VALUE_W-1] == 1'b0) && (value <= VALUE_MAX);
	assign hand        = {(state_q == ST_HOLD), bcd_q};

	always_comb begin
		bcd_adj = bcd_q;
		for (int i = 0; i < DIG_EFF; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && in_range) begin
						state_q <= ST_SHIFT;
						cnt_q   <= CNT_W'(BIN_W);
					end
				end
				ST_SHIFT: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (hand_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bin_q <= value[BIN_W-1:0];
			bcd_q <= '0;
		end else if (state_q == ST_SHIFT) begin
			{bcd_q, bin_q} <= {bcd_adj[BCD_W-2:0], bin_q, 1'b0};
		end
	end

	`SSCN_ASSERT_NXT(a_load_shift, accept && in_range, state_q == ST_SHIFT && cnt_q == CNT_W'(BIN_W), "conv: accepted number did not start shifting")
	`SSCN_ASSERT_NXT(a_shift_done, state_q == ST_SHIFT && cnt_q == CNT_W'(1), state_q == ST_HOLD, "conv: shift did not end in hold")
	`SSCN_ASSERT_NXT(a_drop_range, accept && !in_range, state_q == ST_IDLE, "conv: out-of-range number was not dropped")

endmodule

`default_nettype wire

### src/sscn_emit.sv
// ---------------------------------------------------------------------------
// Digit emitter
// Takes a BCD word, shifts out leading zeros one digit a cycle, then sends
// one digit beat per digit through the output register, most significant first.
// ---------------------------------------------------------------------------
`default_nettype none
`include "seven_segment_number_scanner_unit_defines.svh"

module sscn_emit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire sscn_pkg::sscn_hand_t        hand,
	output logic                             hand_ready,
	output logic [sscn_pkg::POS_W-1:0]       position,
	output logic [sscn_pkg::SEG_W-1:0]       segments,
	output logic                             last,
	output logic                             digit_valid,
	input  wire logic                        digit_stall
);
	import sscn_pkg::*;

	logic [BCD_W-1:0] digit_q;
	logic [REM_W-1:0] rem_q;
	logic             strip_q;
	logic [POS_W-1:0] pos_q;
	logic             digit_valid_q;
	logic [POS_W-1:0] position_q;
	logic [SEG_W-1:0] segments_q;
	logic             last_q;
	logic [3:0]       top;
	logic             take;
	logic             adv;

	assign top        = digit_q[BCD_W-1 -: 4];
	assign hand_ready = (rem_q == '0);
	assign take       = hand.valid && hand_ready;
	assign adv        = (rem_q != '0) && !strip_q && (!digit_valid_q || !digit_stall);

	assign position    = position_q;
	assign segments    = segments_q;
	assign last        = last_q;
	assign digit_valid = digit_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q         <= '0;
			strip_q       <= 1'b0;
			digit_valid_q <= 1'b0;
		end else begin
			if (take) begin
				rem_q   <= REM_W'(DIG_EFF);
				strip_q <= 1'b1;
			end else if (strip_q) begin
				if (top == 4'd0 && rem_q > REM_W'(1)) begin
					rem_q <= rem_q - REM_W'(1);
				end else begin
					strip_q <= 1'b0;
				end
			end else if (adv) begin
				rem_q <= rem_q - REM_W'(1);
			end
			if (adv) begin
				digit_valid_q <= 1'b1;
			end else if (!digit_stall) begin
				digit_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			digit_q <= hand.bcd;
			pos_q   <= '0;
		end else if (strip_q) begin
			if (top == 4'd0 && rem_q > REM_W'(1)) begin
				digit_q <= digit_q << 4;
			end
		end else if (adv) begin
			digit_q    <= digit_q << 4;
			pos_q      <= pos_q + POS_W'(1);
			position_q <= pos_q;
			segments_q <= seg_of(top);
			last_q     <= (rem_q == REM_W'(1));
		end
	end

	`SSCN_ASSERT_IMP(a_strip_rem, strip_q, rem_q != '0, "emit: stripping with no digits left")
	`SSCN_ASSERT_NXT(a_next_digit, digit_valid_q && !digit_stall && !last_q, digit_valid_q && position_q == $past(position_q) + POS_W'(1), "emit: gap or skip inside a number")
	`SSCN_ASSERT_IMP(a_first_pos, digit_valid_q && position_q == '0 && !last_q, !strip_q, "emit: first digit sent while stripping")

endmodule

`default_nettype wire

### src/seven_segment_number_scanner_unit.sv
// ---------------------------------------------------------------------------
// Seven-segment number scanner
// An accepted number runs the bit-serial BCD shift, one step per bit of
// its 14-bit binary form, is handed off, drops up to 3 leading zeros, then
// goes out one digit beat a cycle while digit_stall is low. A new number is
// taken once the last is handed off; out-of-range ones drop at acceptance.
// Reset clears all control state; nothing is in flight after reset.
// ---------------------------------------------------------------------------
`default_nettype none

module seven_segment_number_scanner_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic signed [sscn_pkg::VALUE_W-1:0] value,
	input  wire logic                                value_valid,
	output logic                                     value_stall,
	output logic [sscn_pkg::POS_W-1:0]               position,
	output logic [sscn_pkg::SEG_W-1:0]               segments,
	output logic                                     last,
	output logic                                     digit_valid,
	input  wire logic                                digit_stall
);
	import sscn_pkg::*;

	sscn_hand_t hand;
	logic       hand_ready;

	sscn_conv u_conv (
		.clk         (clk),
		.arst_n      (arst_n),
		.value       (value),
		.value_valid (value_valid),
		.value_stall (value_stall),
		.hand_ready  (hand_ready),
		.hand        (hand)
	);

	sscn_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.hand        (hand),
		.hand_ready  (hand_ready),
		.position    (position),
		.segments    (segments),
		.last        (last),
		.digit_valid (digit_valid),
		.digit_stall (digit_stall)
	);

endmodule

`default_nettype wire
